// ----- sv/sfa_pkg.sv -----
// shared types and constants of the soft float arithmetic unit
package sfa_pkg;

    // exponent widths: the port width and the internal working width
    localparam int EXP_W     = 16;
    localparam int EXT_EXP_W = 19;
    localparam int EXP_MAX   = 32767;
    localparam int EXP_MIN   = -32768;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_GT  = 3'd4,
        CMD_INT = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DIVZ  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // per-beat result flags that ride along with the data
    typedef struct packed {
        logic    pass;
        logic    gt;
        status_t st;
    } sfa_flags_t;

endpackage

// ----- sv/sfa_div.sv -----
// pipelined restoring divider, one quotient bit per stage, with a side payload
module sfa_div #(
    parameter int W      = 16,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [W-1:0]      dividend,
    input  logic [W-1:0]      divisor,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [2*W-1:0]    quotient,
    output logic [SIDE_W-1:0] out_side
);

    localparam int N = 2 * W;

    logic [N-1:0]      v_reg;
    logic [W-1:0]      rem_reg  [N];
    logic [N-1:0]      acc_reg  [N];
    logic [W-1:0]      dv_reg   [N];
    logic [SIDE_W-1:0] side_reg [N];

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic              v_in;
        logic [W-1:0]      rem_in;
        logic [N-1:0]      acc_in;
        logic [W-1:0]      dv_in;
        logic [SIDE_W-1:0] side_in;
        logic [W:0]        sh;
        logic [W+1:0]      diff;
        logic              q_bit;
        logic [W-1:0]      rem_next;
        logic [N-1:0]      acc_next;

        // stage source: ports for the first stage, previous stage otherwise
        if (i == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign acc_in  = {dividend, {W{1'b0}}};
            assign dv_in   = divisor;
            assign side_in = in_side;
        end else begin : g_next
            assign v_in    = v_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign acc_in  = acc_reg[i-1];
            assign dv_in   = dv_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        // trial subtract of the divisor from the shifted remainder
        assign sh       = {rem_in, acc_in[N-1]};
        assign diff     = {1'b0, sh} - {2'b00, dv_in};
        assign q_bit    = ~diff[W+1];
        assign rem_next = q_bit ? diff[W-1:0] : sh[W-1:0];
        assign acc_next = {acc_in[N-2:0], q_bit};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                acc_reg[i]  <= acc_next;
                dv_reg[i]   <= dv_in;
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign quotient  = acc_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

// ----- sv/sfa_norm.sv -----
// three-stage normalizer: length search, shift, round fix and exponent clamp
module sfa_norm
    import sfa_pkg::*;
#(
    parameter int W = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic                        in_neg,
    input  logic [2*W:0]                in_mag,
    input  logic signed [EXT_EXP_W-1:0] in_exp,
    input  sfa_flags_t                  in_flags,
    input  logic [W-1:0]                in_pm,
    input  logic [EXP_W-1:0]            in_pe,
    output logic                        out_valid,
    output logic [W-1:0]                out_mantissa,
    output logic [EXP_W-1:0]            out_exponent,
    output logic                        out_greater,
    output status_t                     out_status
);

    localparam int MAGW = 2 * W + 1;
    localparam int LW   = $clog2(MAGW + 1);
    localparam int KW   = LW + 2;
    localparam logic [W-1:0] HI = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] LO = {2'b01, {(W-2){1'b0}}};

    // stage 1 registers
    logic                        n1_valid_reg;
    logic                        n1_neg_reg;
    logic [MAGW-1:0]             n1_mag_reg;
    logic signed [EXT_EXP_W-1:0] n1_exp_reg;
    logic [LW-1:0]               n1_len_reg;
    sfa_flags_t                  n1_flags_reg;
    logic [W-1:0]                n1_pm_reg;
    logic [EXP_W-1:0]            n1_pe_reg;
    logic [LW-1:0]               len_next;

    // stage 2 registers
    logic                        n2_valid_reg;
    logic                        n2_neg_reg;
    logic                        n2_zero_reg;
    logic [W-1:0]                n2_r_reg;
    logic signed [EXT_EXP_W-1:0] n2_exp_reg;
    sfa_flags_t                  n2_flags_reg;
    logic [W-1:0]                n2_pm_reg;
    logic [EXP_W-1:0]            n2_pe_reg;
    logic [W-1:0]                r_next;
    logic signed [EXT_EXP_W-1:0] exp2_next;

    // stage 3 (output) registers
    logic                        n3_valid_reg;
    logic [W-1:0]                n3_m_reg;
    logic [EXP_W-1:0]            n3_e_reg;
    logic                        n3_gt_reg;
    status_t                     n3_st_reg;
    logic [W-1:0]                m3_next;
    logic [EXP_W-1:0]            e3_next;
    logic                        gt3_next;
    status_t                     st3_next;

    // bit length of the magnitude
    always_comb
    begin
        len_next = '0;
        for (int i = 0; i < MAGW; i++)
        begin
            if (in_mag[i])
            begin
                len_next = LW'(i + 1);
            end
        end
    end

    // shift into [2^(W-2), 2^(W-1)); negative values round toward minus infinity
    always_comb
    begin
        logic signed [KW-1:0] kk;
        logic [LW-1:0]        kpos;
        logic [LW-1:0]        kneg;
        logic [MAGW-1:0]      shifted;
        logic                 sticky;
        kk      = $signed({2'b00, n1_len_reg}) - KW'(W - 1);
        kpos    = LW'(kk);
        kneg    = LW'(-kk);
        shifted = n1_mag_reg >> kpos;
        sticky  = |(n1_mag_reg & ~({MAGW{1'b1}} << kpos));
        if (kk > 0)
        begin
            r_next = W'(shifted) + W'(n1_neg_reg & sticky);
        end
        else
        begin
            r_next = W'(n1_mag_reg << kneg);
        end
        exp2_next = n1_exp_reg + EXT_EXP_W'(kk);
    end

    // carry fix, sign, exponent clamp, zero result and pass-through select
    always_comb
    begin
        logic [W-1:0]                r3;
        logic signed [EXT_EXP_W-1:0] ex3;
        r3  = n2_r_reg;
        ex3 = n2_exp_reg;
        if (n2_r_reg == HI)
        begin
            r3  = LO;
            ex3 = n2_exp_reg + EXT_EXP_W'(1);
        end
        m3_next  = n2_neg_reg ? W'(-r3) : r3;
        gt3_next = 1'b0;
        st3_next = ST_OK;
        if (ex3 > EXT_EXP_W'(EXP_MAX))
        begin
            e3_next  = EXP_W'(EXP_MAX);
            st3_next = ST_RANGE;
        end
        else if (ex3 < EXT_EXP_W'(EXP_MIN))
        begin
            e3_next  = EXP_W'(EXP_MIN);
            st3_next = ST_RANGE;
        end
        else
        begin
            e3_next = EXP_W'(ex3);
        end
        if (n2_zero_reg)
        begin
            m3_next  = '0;
            e3_next  = '0;
            st3_next = ST_OK;
        end
        if (n2_flags_reg.pass)
        begin
            m3_next  = n2_pm_reg;
            e3_next  = n2_pe_reg;
            gt3_next = n2_flags_reg.gt;
            st3_next = n2_flags_reg.st;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n1_valid_reg <= 1'b0;
            n2_valid_reg <= 1'b0;
            n3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            n1_valid_reg <= in_valid;
            n2_valid_reg <= n1_valid_reg;
            n3_valid_reg <= n2_valid_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_neg_reg   <= in_neg;
            n1_mag_reg   <= in_mag;
            n1_exp_reg   <= in_exp;
            n1_len_reg   <= len_next;
            n1_flags_reg <= in_flags;
            n1_pm_reg    <= in_pm;
            n1_pe_reg    <= in_pe;

            n2_neg_reg   <= n1_neg_reg;
            n2_zero_reg  <= (n1_len_reg == '0);
            n2_r_reg     <= r_next;
            n2_exp_reg   <= exp2_next;
            n2_flags_reg <= n1_flags_reg;
            n2_pm_reg    <= n1_pm_reg;
            n2_pe_reg    <= n1_pe_reg;

            n3_m_reg     <= m3_next;
            n3_e_reg     <= e3_next;
            n3_gt_reg    <= gt3_next;
            n3_st_reg    <= st3_next;
        end
    end

    assign out_valid    = n3_valid_reg;
    assign out_mantissa = n3_m_reg;
    assign out_exponent = n3_e_reg;
    assign out_greater  = n3_gt_reg;
    assign out_status   = n3_st_reg;

endmodule

// ----- sv/soft_float_arith_unit.sv -----
// top level of the soft float arithmetic unit
//
//  channel  | signals                      | beat contents (low bit first)
//  ---------+------------------------------+-----------------------------------------------
//  input    | s_tvalid s_tready s_tdata    | tdata: a_mantissa, a_exponent, b_mantissa,
//           | s_tuser                      |   b_exponent; tuser: command
//  output   | m_tvalid m_tready m_tdata    | tdata: result_mantissa, result_exponent,
//           |                              |   greater_flag, status
//
// one beat is taken every cycle while the pipeline advances; a result passes the
// operand stage, the divider (one quotient bit per stage), the sum and magnitude
// stages and the normalizer. rst_n clears only the valid bits. the whole pipeline
// holds while the output register is full and m_tready is low, and runs otherwise.
module soft_float_arith_unit
    import sfa_pkg::*;
#(
    parameter int MANT_WIDTH = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // a_mantissa, a_exponent, b_mantissa, b_exponent, zero pad
    input  logic [((2*MANT_WIDTH+32+7)/8)*8-1:0]      s_tdata,
    // command
    input  logic [2:0]                                s_tuser,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // result_mantissa, result_exponent, greater_flag, status, zero pad
    output logic [((MANT_WIDTH+19+7)/8)*8-1:0]        m_tdata
);

    localparam int W      = MANT_WIDTH;
    localparam int W2     = 2 * W;
    localparam int SUMW   = 2 * W + 2;
    localparam int MAGW   = 2 * W + 1;
    localparam int IW     = $clog2(W);
    localparam int SHW    = $clog2(W + 2);
    localparam int OUT_DW = ((W + 19 + 7) / 8) * 8;
    localparam logic signed [W:0] HI1 = {2'b01, {(W-1){1'b0}}};

    typedef struct packed {
        cmd_t                        cmd;
        sfa_flags_t                  flags;
        logic [W-1:0]                pm;
        logic [EXP_W-1:0]            pe;
        logic signed [EXT_EXP_W-1:0] ne;
        logic                        dneg;
        logic signed [W:0]           xm;
        logic signed [W:0]           ym;
        logic [16:0]                 d;
        logic signed [W2-1:0]        prod;
    } p1_t;

    typedef struct packed {
        cmd_t                        cmd;
        sfa_flags_t                  flags;
        logic [W-1:0]                pm;
        logic [EXP_W-1:0]            pe;
        logic signed [EXT_EXP_W-1:0] ne;
        logic                        dneg;
        logic signed [SUMW-1:0]      sval;
        logic [W2-1:0]               q;
    } p2_t;

    logic                 adv;
    cmd_t                 cmd;
    logic signed [W-1:0]  a_m;
    logic signed [W-1:0]  b_m;
    logic signed [15:0]   a_e;
    logic signed [15:0]   b_e;

    p1_t                  p1_next;
    p1_t                  p1_reg;
    logic                 p1_valid_reg;
    logic [W-1:0]         ma_next;
    logic [W-1:0]         mb_next;
    logic [W-1:0]         ma_reg;
    logic [W-1:0]         mb_reg;

    logic                 dv_valid;
    logic [W2-1:0]        dv_q;
    logic [$bits(p1_t)-1:0] dv_side;
    p1_t                  p1d;

    p2_t                  p2_next;
    p2_t                  p2_reg;
    logic                 p2_valid_reg;

    logic                        p3_valid_reg;
    logic                        p3_neg_reg;
    logic [MAGW-1:0]             p3_mag_reg;
    logic signed [EXT_EXP_W-1:0] p3_exp_reg;
    sfa_flags_t                  p3_flags_reg;
    logic [W-1:0]                p3_pm_reg;
    logic [EXP_W-1:0]            p3_pe_reg;
    logic                        neg3_next;
    logic [MAGW-1:0]             mag3_next;

    logic                 res_valid;
    logic [W-1:0]         res_m;
    logic [EXP_W-1:0]     res_e;
    logic                 res_gt;
    status_t              res_st;

    // whole pipeline moves unless a finished beat is stuck at the output
    assign adv      = !res_valid || m_tready;
    assign s_tready = adv;

    // input unpack
    assign cmd = cmd_t'(s_tuser);
    assign a_m = s_tdata[W-1:0];
    assign a_e = s_tdata[W+15:W];
    assign b_m = s_tdata[2*W+15:W+16];
    assign b_e = s_tdata[2*W+31:2*W+16];

    // stage 1: operand prep, multiply, compare, integer conversion
    always_comb
    begin
        logic signed [W:0]    am1;
        logic signed [W:0]    bme;
        logic signed [1:0]    sa;
        logic signed [1:0]    sb;
        logic signed [W2-1:0] shl;
        logic [16:0]          na;
        logic [W-1:0]         iv;
        status_t              ist;
        am1 = (W+1)'(a_m);
        bme = (cmd == CMD_SUB) ? -((W+1)'(b_m)) : (W+1)'(b_m);
        sa  = a_m[W-1] ? 2'sb11 : ((a_m != '0) ? 2'sb01 : 2'sb00);
        sb  = b_m[W-1] ? 2'sb11 : ((b_m != '0) ? 2'sb01 : 2'sb00);
        shl = W2'(a_m) <<< a_e[IW-1:0];
        na  = -(17'(a_e));
        iv  = '0;
        ist = ST_OK;

        p1_next       = '0;
        p1_next.cmd   = cmd;
        p1_next.flags = '{pass: 1'b1, gt: 1'b0, st: ST_OK};
        ma_next       = a_m[W-1] ? W'(-a_m) : a_m;
        mb_next       = b_m[W-1] ? W'(-b_m) : b_m;

        case (cmd)
            CMD_ADD, CMD_SUB:
            begin
                if (am1 == '0)
                begin
                    if (bme == HI1)
                    begin
                        p1_next.flags.pass = 1'b0;
                        p1_next.xm         = bme;
                        p1_next.ne         = EXT_EXP_W'(b_e) - EXT_EXP_W'(W - 1);
                    end
                    else
                    begin
                        p1_next.pm = bme[W-1:0];
                        p1_next.pe = b_e;
                    end
                end
                else if (bme == '0)
                begin
                    p1_next.pm = a_m;
                    p1_next.pe = a_e;
                end
                else if (b_e > a_e)
                begin
                    p1_next.flags.pass = 1'b0;
                    p1_next.xm         = bme;
                    p1_next.ym         = am1;
                    p1_next.d          = 17'(b_e) - 17'(a_e);
                    p1_next.ne         = EXT_EXP_W'(b_e) - EXT_EXP_W'(W - 1);
                end
                else
                begin
                    p1_next.flags.pass = 1'b0;
                    p1_next.xm         = am1;
                    p1_next.ym         = bme;
                    p1_next.d          = 17'(a_e) - 17'(b_e);
                    p1_next.ne         = EXT_EXP_W'(a_e) - EXT_EXP_W'(W - 1);
                end
            end
            CMD_MUL:
            begin
                p1_next.flags.pass = 1'b0;
                p1_next.prod       = W2'(a_m) * W2'(b_m);
                p1_next.ne         = EXT_EXP_W'(a_e) + EXT_EXP_W'(b_e) + EXT_EXP_W'(W - 2);
            end
            CMD_DIV:
            begin
                if (b_m == '0)
                begin
                    p1_next.flags.st = ST_DIVZ;
                end
                else
                begin
                    p1_next.flags.pass = 1'b0;
                    p1_next.dneg       = a_m[W-1] ^ b_m[W-1];
                    p1_next.ne         = EXT_EXP_W'(a_e) - EXT_EXP_W'(b_e) - EXT_EXP_W'(W);
                end
            end
            CMD_GT:
            begin
                if (sa > sb)
                begin
                    p1_next.flags.gt = 1'b1;
                end
                else if (sb > sa)
                begin
                    p1_next.flags.gt = 1'b0;
                end
                else if (a_e > b_e)
                begin
                    p1_next.flags.gt = (sa > 2'sb00);
                end
                else if (b_e > a_e)
                begin
                    p1_next.flags.gt = (sa < 2'sb00);
                end
                else
                begin
                    p1_next.flags.gt = (a_m > b_m);
                end
            end
            CMD_INT:
            begin
                if (a_e > 16'sd0)
                begin
                    if (a_m == '0)
                    begin
                        iv = '0;
                    end
                    else if (a_e >= 16'(W))
                    begin
                        iv  = a_m[W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
                        ist = ST_RANGE;
                    end
                    else if ((shl[W2-1:W-1] == '0) || (shl[W2-1:W-1] == '1))
                    begin
                        iv = shl[W-1:0];
                    end
                    else
                    begin
                        iv  = a_m[W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
                        ist = ST_RANGE;
                    end
                end
                else if (na > 17'(W - 1))
                begin
                    iv = '0;
                end
                else
                begin
                    iv = a_m >>> na[IW-1:0];
                end
                p1_next.pm       = iv;
                p1_next.flags.st = ist;
            end
            default:
            begin
                p1_next.flags.pass = 1'b1;
            end
        endcase
    end

    // stage 2: add alignment and sum, product scaling, quotient capture
    always_comb
    begin
        logic [SHW-1:0]         lsh;
        logic [SHW-1:0]         rsh;
        logic signed [SUMW-1:0] bterm;
        lsh = SHW'(W - 1) - SHW'(p1d.d);
        rsh = (p1d.d > 17'(2 * W)) ? SHW'(W + 1) : SHW'(p1d.d - 17'(W - 1));
        if (p1d.d <= 17'(W - 1))
        begin
            bterm = SUMW'(p1d.ym) <<< lsh;
        end
        else
        begin
            bterm = SUMW'(p1d.ym) >>> rsh;
        end
        p2_next       = '0;
        p2_next.cmd   = p1d.cmd;
        p2_next.flags = p1d.flags;
        p2_next.pm    = p1d.pm;
        p2_next.pe    = p1d.pe;
        p2_next.ne    = p1d.ne;
        p2_next.dneg  = p1d.dneg;
        p2_next.q     = dv_q;
        if (p1d.cmd == CMD_MUL)
        begin
            p2_next.sval = SUMW'(p1d.prod >>> (W - 2));
        end
        else
        begin
            p2_next.sval = (SUMW'(p1d.xm) <<< (W - 1)) + bterm;
        end
    end

    // stage 3: sign and magnitude for the normalizer
    always_comb
    begin
        if (p2_reg.cmd == CMD_DIV)
        begin
            neg3_next = p2_reg.dneg;
            mag3_next = MAGW'(p2_reg.q);
        end
        else
        begin
            neg3_next = p2_reg.sval[SUMW-1];
            mag3_next = MAGW'(p2_reg.sval[SUMW-1] ? -p2_reg.sval : p2_reg.sval);
        end
    end

    // valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg <= s_tvalid;
            p2_valid_reg <= dv_valid;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    // payload of the front stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg       <= p1_next;
            ma_reg       <= ma_next;
            mb_reg       <= mb_next;
            p2_reg       <= p2_next;
            p3_neg_reg   <= neg3_next;
            p3_mag_reg   <= mag3_next;
            p3_exp_reg   <= p2_reg.ne;
            p3_flags_reg <= p2_reg.flags;
            p3_pm_reg    <= p2_reg.pm;
            p3_pe_reg    <= p2_reg.pe;
        end
    end

    // quotient pipeline, carries the prepared beat alongside
    sfa_div #(
        .W      (W),
        .SIDE_W ($bits(p1_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (p1_valid_reg),
        .dividend  (ma_reg),
        .divisor   (mb_reg),
        .in_side   (p1_reg),
        .out_valid (dv_valid),
        .quotient  (dv_q),
        .out_side  (dv_side)
    );

    assign p1d = dv_side;

    // normalize, clamp and register the result
    sfa_norm #(
        .W (W)
    ) u_norm (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (adv),
        .in_valid     (p3_valid_reg),
        .in_neg       (p3_neg_reg),
        .in_mag       (p3_mag_reg),
        .in_exp       (p3_exp_reg),
        .in_flags     (p3_flags_reg),
        .in_pm        (p3_pm_reg),
        .in_pe        (p3_pe_reg),
        .out_valid    (res_valid),
        .out_mantissa (res_m),
        .out_exponent (res_e),
        .out_greater  (res_gt),
        .out_status   (res_st)
    );

    // output pack
    assign m_tvalid = res_valid;
    assign m_tdata  = {{(OUT_DW - W - 19){1'b0}}, res_st, res_gt, res_e, res_m};

    // divide by zero gives an all-zero value
    a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_st == ST_DIVZ) |-> (res_m == '0 && res_e == '0))
        else $error("divide by zero beat carries a nonzero value");

    // a set compare flag comes with a clean zero value and ok status
    a_gt_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_gt) |-> (res_m == '0 && res_e == '0 && res_st == ST_OK))
        else $error("compare beat carries a value or a status");

    // the input side only waits for a blocked output register
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a blocked output");

endmodule
